[design/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared constants and types for the free subnet picker: table geometry,
// candidate range bounds and the control struct that drives the candidate
// generator.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Host network table geometry.
  localparam int MAX_HOST_NETS = 16;
  localparam int IDX_W = (MAX_HOST_NETS > 1) ? $clog2(MAX_HOST_NETS) : 1;
  localparam int CNT_W = $clog2(MAX_HOST_NETS + 1);

  // Networks are compared as 24-bit prefixes; the low byte never matters.
  localparam int PFX_W = 24;
  localparam int ENTRY_W = 2 * PFX_W;

  localparam logic [31:0] MASK24 = 32'hFFFF_FF00;

  // Candidate prefixes (address bits 31:8).
  localparam logic [PFX_W-1:0] PFX_FALLBACK = 24'h0A_00_02;
  localparam logic [PFX_W-1:0] PFX_TEN_LAST = 24'h0A_0A_FF;
  localparam logic [PFX_W-1:0] PFX_172_FIRST = 24'hAC_10_00;
  localparam logic [PFX_W-1:0] PFX_172_LAST = 24'hAC_1F_0F;
  localparam logic [7:0] PFX_172_SUB_LAST = 8'h0F;
  localparam logic [PFX_W-1:0] PFX_192_FIRST = 24'hC0_A8_FE;
  localparam logic [PFX_W-1:0] PFX_192_LAST = 24'hC0_A8_00;

  // Host offsets inside the chosen /24.
  localparam logic [7:0] OFS_GATEWAY = 8'h02;
  localparam logic [7:0] OFS_DNS = 8'h03;
  localparam logic [7:0] OFS_DHCP = 8'h0F;

  // Input mode codes.
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Control from the search sequencer to the candidate generator.
  typedef struct packed {
    logic start;
    logic advance;
  } cand_ctl_t;

endpackage

[design/fsp_table_ram.sv]
// ----------------------------------------------------------------------------
// fsp_table_ram
// Host network table: one write port and one read port, registered read
// data. Each entry holds a masked network prefix and its /24-clipped mask.
// ----------------------------------------------------------------------------
module fsp_table_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [fsp_pkg::IDX_W-1:0]     wr_addr,
  input  logic [fsp_pkg::ENTRY_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [fsp_pkg::IDX_W-1:0]     rd_addr,
  output logic [fsp_pkg::ENTRY_W-1:0]   rd_data
);
  import fsp_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_HOST_NETS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/fsp_cand_gen.sv]
// ----------------------------------------------------------------------------
// fsp_cand_gen
// Walks the private /24 candidate order: 10.0.2 up to 10.10.255, then
// 172.16-31 with third octet 0-15, then 192.168.254 down to 192.168.0.
// ----------------------------------------------------------------------------
module fsp_cand_gen (
  input  logic                       clk,
  input  logic                       rst,
  input  fsp_pkg::cand_ctl_t         ctl,
  output logic [fsp_pkg::PFX_W-1:0]  prefix,
  output logic                       last
);
  import fsp_pkg::*;

  localparam logic [1:0] PH_TEN = 2'd0;
  localparam logic [1:0] PH_172 = 2'd1;
  localparam logic [1:0] PH_192 = 2'd2;

  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [PFX_W-1:0] prefix_next;

  // Next candidate in the fixed order.
  always_comb begin
    phase_next  = phase;
    prefix_next = prefix;
    case (phase)
      PH_TEN: begin
        if (prefix == PFX_TEN_LAST) begin
          phase_next  = PH_172;
          prefix_next = PFX_172_FIRST;
        end else begin
          prefix_next = prefix + 24'd1;
        end
      end
      PH_172: begin
        if (prefix == PFX_172_LAST) begin
          phase_next  = PH_192;
          prefix_next = PFX_192_FIRST;
        end else if (prefix[7:0] == PFX_172_SUB_LAST) begin
          prefix_next = {prefix[23:16], prefix[15:8] + 8'd1, 8'h00};
        end else begin
          prefix_next = prefix + 24'd1;
        end
      end
      PH_192: begin
        prefix_next = prefix - 24'd1;
      end
      default: begin
        phase_next  = PH_TEN;
        prefix_next = PFX_FALLBACK;
      end
    endcase
  end

  // Candidate register: restarts on a new search, steps on each rejection.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_TEN;
      prefix <= PFX_FALLBACK;
    end else if (ctl.start) begin
      phase  <= PH_TEN;
      prefix <= PFX_FALLBACK;
    end else if (ctl.advance) begin
      phase  <= phase_next;
      prefix <= prefix_next;
    end
  end

  assign last = (phase == PH_192) && (prefix == PFX_192_LAST);

endmodule

[design/free_subnet_picker_top.sv]
// ----------------------------------------------------------------------------
// free_subnet_picker_top
// Collects host networks into a table and, on request, picks the first
// private /24 that overlaps none of them.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, mode, host_address,  | into block
//           | host_mask                                |
//   out     | out_valid, out_stall, net_base, net_mask,| out of block
//           | gateway_addr, dns_addr, dhcp_first,      |
//           | found_free, table_overflowed             |
//
// A search beat walks the 3325 candidates in order; for each candidate the
// table entries are read one at a time through the single read port until
// the first overlap, and the walk restarts on the next candidate. The result
// then passes through a hold state into the output register.
// Reset is synchronous and empties the table. A stall on the output holds the
// result; the input is stalled while a search runs or waits to be delivered.
// ----------------------------------------------------------------------------
module free_subnet_picker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] host_address,
  input  logic [31:0] host_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] net_base,
  output logic [31:0] net_mask,
  output logic [31:0] gateway_addr,
  output logic [31:0] dns_addr,
  output logic [31:0] dhcp_first,
  output logic        found_free,
  output logic        table_overflowed
);
  import fsp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  entry_count;
  logic              overflow_seen;

  logic [IDX_W-1:0]  idx;
  logic              issuing;
  logic              pend;
  logic              pend_last;
  logic              issue_last;

  logic [PFX_W-1:0]  res_prefix;
  logic              res_found;
  logic              res_ovf;

  logic              in_beat;
  logic              add_beat;
  logic              search_beat;
  logic              table_full;
  logic              wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [PFX_W-1:0]  rd_net;
  logic [PFX_W-1:0]  rd_mask;
  logic              hit;
  logic              out_free;

  cand_ctl_t         cand_ctl;
  logic [PFX_W-1:0]  cand;
  logic              cand_last;

  // Input handshake decode.
  assign in_stall    = (state != ST_IDLE);
  assign in_beat     = in_valid && !in_stall;
  assign add_beat    = in_beat && (mode == MODE_ADD) && (host_mask != 32'd0);
  assign search_beat = in_beat && (mode == MODE_SEARCH);
  assign table_full  = (entry_count == CNT_W'(MAX_HOST_NETS));

  // Table write: prefix already masked, mask clipped to /24.
  assign wr_en   = add_beat && !table_full;
  assign wr_data = {host_address[31:8] & host_mask[31:8], host_mask[31:8]};

  fsp_table_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issuing),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Overlap test of the current candidate against the entry just read.
  assign rd_net  = rd_data[ENTRY_W-1:PFX_W];
  assign rd_mask = rd_data[PFX_W-1:0];
  assign hit     = pend && (((rd_net ^ cand) & rd_mask) == '0);
  assign issue_last = ({{(CNT_W-IDX_W){1'b0}}, idx} == (entry_count - CNT_W'(1)));

  // Candidate generator control.
  assign cand_ctl.start   = search_beat;
  assign cand_ctl.advance = (state == ST_SEARCH) && hit && !cand_last;

  fsp_cand_gen u_cand (
    .clk    (clk),
    .rst    (rst),
    .ctl    (cand_ctl),
    .prefix (cand),
    .last   (cand_last)
  );

  assign out_free = !out_valid || !out_stall;

  // Search sequencer and table bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      overflow_seen <= 1'b0;
      issuing       <= 1'b0;
      pend          <= 1'b0;
      pend_last     <= 1'b0;
      idx           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (add_beat) begin
            if (table_full) begin
              overflow_seen <= 1'b1;
            end else begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end else if (search_beat) begin
            if (entry_count == '0) begin
              // Empty table: the first candidate is free.
              res_prefix    <= PFX_FALLBACK;
              res_found     <= 1'b1;
              res_ovf       <= overflow_seen;
              overflow_seen <= 1'b0;
              state         <= ST_HOLD;
            end else begin
              idx       <= '0;
              issuing   <= 1'b1;
              pend      <= 1'b0;
              pend_last <= 1'b0;
              state     <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            if (cand_last) begin
              // No candidate left: fall back.
              res_prefix    <= PFX_FALLBACK;
              res_found     <= 1'b0;
              res_ovf       <= overflow_seen;
              overflow_seen <= 1'b0;
              entry_count   <= '0;
              issuing       <= 1'b0;
              pend          <= 1'b0;
              state         <= ST_HOLD;
            end else begin
              // Overlap: drop the read in flight and restart on the next one.
              idx     <= '0;
              issuing <= 1'b1;
              pend    <= 1'b0;
            end
          end else if (pend && pend_last) begin
            // Every entry passed: the candidate is free.
            res_prefix    <= cand;
            res_found     <= 1'b1;
            res_ovf       <= overflow_seen;
            overflow_seen <= 1'b0;
            entry_count   <= '0;
            issuing       <= 1'b0;
            pend          <= 1'b0;
            state         <= ST_HOLD;
          end else if (issuing) begin
            pend      <= 1'b1;
            pend_last <= issue_last;
            idx       <= idx + IDX_W'(1);
            if (issue_last) begin
              issuing <= 1'b0;
            end
          end else begin
            pend <= 1'b0;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && out_free) begin
      net_base         <= {res_prefix, 8'h00};
      net_mask         <= MASK24;
      gateway_addr     <= {res_prefix, OFS_GATEWAY};
      dns_addr         <= {res_prefix, OFS_DNS};
      dhcp_first       <= {res_prefix, OFS_DHCP};
      found_free       <= res_found;
      table_overflowed <= res_ovf;
    end
  end

endmodule

[dv/free_subnet_picker_top_test.sv]
// ----------------------------------------------------------------------------
// free_subnet_picker_top_test
// Self-checking bench for the free subnet picker. Beats load host networks
// and request searches. An internal predictor tracks the host table and
// walks the private /24 candidates for each search. A monitor checks every
// delivered result against the oldest predicted one. Directed cases cover
// the candidate regions, the fallback, overflow and the last candidate.
// Random traffic runs under varying sender and receiver idling, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module free_subnet_picker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 50;
  localparam int PRESSURE_HOLD = 3000;

  localparam logic [31:0] NET_FALLBACK = 32'h0A00_0200;

  typedef struct packed {
    logic [31:0] net_base;
    logic [31:0] net_mask;
    logic [31:0] gateway_addr;
    logic [31:0] dns_addr;
    logic [31:0] dhcp_first;
    logic        found_free;
    logic        table_overflowed;
  } subnet_pick_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [31:0] host_address;
  logic [31:0] host_mask;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] net_base;
  logic [31:0] net_mask;
  logic [31:0] gateway_addr;
  logic [31:0] dns_addr;
  logic [31:0] dhcp_first;
  logic        found_free;
  logic        table_overflowed;

  // Predictor state: a copy of the host network table.
  logic [31:0] host_net_tbl[MAX_HOST_NETS];
  logic [31:0] host_mask_tbl[MAX_HOST_NETS];
  int          host_count;
  bit          overflow_flag;

  subnet_pick_t pending_picks[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  int           hold_left = 0;

  free_subnet_picker_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .host_address     (host_address),
    .host_mask        (host_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .net_base         (net_base),
    .net_mask         (net_mask),
    .gateway_addr     (gateway_addr),
    .dns_addr         (dns_addr),
    .dhcp_first       (dhcp_first),
    .found_free       (found_free),
    .table_overflowed (table_overflowed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // A candidate is free when no stored network equals it under both masks.
  function automatic bit net_is_free(logic [31:0] cand);
    logic [31:0] m;
    for (int i = 0; i < host_count; i++) begin
      m = host_mask_tbl[i] & MASK24;
      if ((host_net_tbl[i] & m) == (cand & m)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk the candidates in search order and build the expected result.
  function automatic subnet_pick_t predict_search();
    subnet_pick_t p;
    logic [31:0]  net;
    bit           found;
    net = NET_FALLBACK;
    found = net_is_free(net);
    for (int a = 3; a < 256 && !found; a++) begin
      net = {8'h0A, 8'h00, 8'(a), 8'h00};
      found = net_is_free(net);
    end
    for (int a = 1; a <= 10 && !found; a++) begin
      for (int b = 0; b < 256 && !found; b++) begin
        net = {8'h0A, 8'(a), 8'(b), 8'h00};
        found = net_is_free(net);
      end
    end
    for (int a = 16; a <= 31 && !found; a++) begin
      for (int b = 0; b < 16 && !found; b++) begin
        net = {8'hAC, 8'(a), 8'(b), 8'h00};
        found = net_is_free(net);
      end
    end
    for (int x = 254; x >= 0 && !found; x--) begin
      net = {8'hC0, 8'hA8, 8'(x), 8'h00};
      found = net_is_free(net);
    end
    if (!found) net = NET_FALLBACK;
    p.net_base = net;
    p.net_mask = MASK24;
    p.gateway_addr = net + 32'd2;
    p.dns_addr = net + 32'd3;
    p.dhcp_first = net + 32'd15;
    p.found_free = found;
    p.table_overflowed = overflow_flag;
    return p;
  endfunction

  // Append one expected result behind those still waiting.
  function automatic void queue_pick(subnet_pick_t p);
    pending_picks.insert(pending_picks.size(), p);
  endfunction

  // Store a host network; zero masks are dropped, a full table sets overflow.
  function automatic void record_host_net(logic [31:0] addr, logic [31:0] msk);
    if (msk == 32'd0) return;
    if (host_count < MAX_HOST_NETS) begin
      host_net_tbl[host_count] = addr & msk;
      host_mask_tbl[host_count] = msk;
      host_count++;
    end else begin
      overflow_flag = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h expected %08h", name, got, want));
  endtask

  // Monitor: predicts on every accepted input beat, checks every result beat.
  always @(posedge clk) begin
    subnet_pick_t want;
    if (rst) begin
      host_count = 0;
      overflow_flag = 1'b0;
      pending_picks.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (mode == MODE_SEARCH) begin
          queue_pick(predict_search());
          host_count = 0;
          overflow_flag = 1'b0;
        end else begin
          record_host_net(host_address, host_mask);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat net_base %08h", net_base));
        end else begin
          want = pending_picks.pop_front();
          check_field("net_base", net_base, want.net_base);
          check_field("net_mask", net_mask, want.net_mask);
          check_field("gateway_addr", gateway_addr, want.gateway_addr);
          check_field("dns_addr", dns_addr, want.dns_addr);
          check_field("dhcp_first", dhcp_first, want.dhcp_first);
          check_field("found_free", 32'(found_free), 32'(want.found_free));
          check_field("table_overflowed", 32'(table_overflowed),
                      32'(want.table_overflowed));
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", quiet_cycles);
      $display("[free_subnet_picker_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < snk_idle_pct);
      end
    end
  end

  // Offer one input beat and hold it until accepted. Called just after a
  // falling edge; valid stays high on return so back-to-back beats need no
  // low cycle.
  task automatic send_beat(logic beat_mode, logic [31:0] beat_addr,
                           logic [31:0] beat_mask);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= beat_mode;
    host_address <= beat_addr;
    host_mask <= beat_mask;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic add_net(logic [31:0] addr, logic [31:0] msk);
    send_beat(MODE_ADD, addr, msk);
  endtask

  task automatic run_search();
    send_beat(MODE_SEARCH, $urandom, $urandom);
  endtask

  function automatic logic [31:0] prefix_mask(int len);
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Pick a private /24 from one of the candidate regions.
  function automatic logic [31:0] random_candidate();
    case ($urandom_range(3))
      0: return {8'h0A, 8'h00, 8'($urandom_range(2, 255)), 8'h00};
      1: return {8'h0A, 8'($urandom_range(1, 10)), 8'($urandom_range(255)), 8'h00};
      2: return {8'hAC, 8'($urandom_range(16, 31)), 8'($urandom_range(15)), 8'h00};
      default: return {16'hC0A8, 8'($urandom_range(255)), 8'h00};
    endcase
  endfunction

  // Host networks biased toward the candidate regions, plus noise.
  task automatic random_host_net(output logic [31:0] addr, output logic [31:0] msk);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(11))
      0: begin addr = r; msk = 32'd0; end
      1, 2: begin addr = r; msk = $urandom; end
      3: begin addr = r; msk = prefix_mask($urandom_range(1, 32)); end
      4, 5, 10: begin
        addr = random_candidate() | 32'(r[7:0]);
        msk = prefix_mask($urandom_range(16, 32));
      end
      6: begin addr = {8'h0A, r[23:0]}; msk = prefix_mask($urandom_range(8, 16)); end
      7: begin
        addr = {8'hAC, 8'($urandom_range(16, 31)), r[15:0]};
        msk = prefix_mask($urandom_range(12, 20));
      end
      8: begin addr = {16'hC0A8, r[15:0]}; msk = prefix_mask($urandom_range(16, 24)); end
      9: begin addr = r; msk = {24'h0, 8'($urandom_range(1, 255))}; end
      default: begin addr = random_candidate(); msk = MASK24; end
    endcase
  endtask

  // Region boundaries, ignored entries, masks without prefix bits.
  task automatic test_candidate_edges();
    run_search();
    add_net(32'h0A00_024D, MASK24);
    run_search();
    add_net(32'h0A00_0300, 32'h0000_0000);
    run_search();
    add_net(32'h0A00_0000, 32'hFFFF_0000);
    run_search();
    add_net(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_net(32'h0000_0000, 32'h8000_0000);
    run_search();
    add_net(32'h0A12_3456, 32'hFF00_0000);
    add_net(32'hAC10_0000, 32'hFFF0_0000);
    run_search();
    add_net(32'h1234_5678, 32'h0000_00FF);
    run_search();
  endtask

  // Overflow, the last candidate, and a full-table exhaustive search.
  task automatic test_table_limits();
    for (int i = 0; i <= MAX_HOST_NETS; i++) add_net({8'h01, 8'(i), 16'h0000}, 32'hFFFF_0000);
    run_search();
    run_search();
    add_net(32'h0A00_0000, 32'hFF00_0000);
    add_net(32'hAC10_0000, 32'hFFF0_0000);
    for (int len = 17; len <= 24; len++)
      add_net(32'hC0A8_0000 | (32'h1 << (32 - len)), prefix_mask(len));
    run_search();
    for (int i = 0; i < MAX_HOST_NETS - 3; i++) add_net({8'h01, 8'(i), 16'h0000}, 32'hFFFF_0000);
    add_net(32'h0A00_0000, 32'hFF00_0000);
    add_net(32'hAC10_0000, 32'hFFF0_0000);
    add_net(32'hC0A8_0000, 32'hFFFF_0000);
    run_search();
  endtask

  // Runs of host networks, each closed by a search.
  task automatic test_random_traffic(int src_pct, int snk_pct, int beats);
    int          sent;
    int          n_adds;
    logic [31:0] addr;
    logic [31:0] msk;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < beats) begin
      n_adds = ($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      repeat (n_adds) begin
        random_host_net(addr, msk);
        add_net(addr, msk);
        if (msk != 32'd0) sent++;
      end
      run_search();
      sent++;
    end
  endtask

  // The receiver holds off while beats keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_left = PRESSURE_HOLD;
    run_search();
    add_net(32'h0A00_0200, MASK24);
    add_net(32'h0A00_0300, 32'hFFFF_FF80);
    add_net(32'h0A00_0400, MASK24);
    run_search();
    add_net(32'hC0A8_FE00, MASK24);
    run_search();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ADD;
    host_address = 32'd0;
    host_mask = 32'd0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 35;
    snk_idle_pct = 72;
    test_candidate_edges();
    test_table_limits();
    test_random_traffic(35, 72, 35);
    test_random_traffic(72, 35, 35);
    test_random_traffic(0, 0, 30);
    test_output_backpressure();
    in_valid <= 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[free_subnet_picker_top] OK");
    else
      $display("[free_subnet_picker_top] ERROR");
    $finish;
  end

endmodule
